/* src/lia_pkg.sv */
// Package for the LIFO identifier allocator.
// Holds the beat payload types, status and action codes, sequencer state and control struct.
// No dependencies.
package lia_pkg;

    // Fixed field widths of the beat payloads
    localparam int unsigned REQ_ID_W = 8;
    localparam int unsigned GRANT_W  = 6;
    localparam int unsigned COUNT_W  = 7;

    // Request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_DUP   = 2'd3
    } status_t;

    // Request beat
    typedef struct packed {
        logic                action;
        logic [REQ_ID_W-1:0] req_id;
    } lia_in_t;

    // Result beat
    typedef struct packed {
        status_t              status;
        logic [GRANT_W-1:0]   granted_id;
        logic [COUNT_W-1:0]   free_count;
    } lia_out_t;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Strobes from the sequencer to the pool datapath
    typedef struct packed {
        logic issue;   // request accepted: latch it and start memory reads
        logic commit;  // read data ready and result slot free: write back
    } lia_ctrl_t;

endpackage

/* src/lia_ctrl.sv */
// Two-step sequencer of the LIFO identifier allocator: read, then write back.
// Depends on lia_pkg.
module lia_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              slot_free,
    output logic              in_ready,
    output lia_pkg::lia_ctrl_t ctrl
);

    lia_pkg::state_t state_reg;
    lia_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lia_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance on an accepted beat, return once the result is loaded
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lia_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lia_pkg::S_EXEC;
                end
            end
            lia_pkg::S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = lia_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lia_pkg::S_IDLE;
            end
        endcase
    end

    // Drive ready and the datapath strobes
    always_comb
    begin
        in_ready    = 1'b0;
        ctrl.issue  = 1'b0;
        ctrl.commit = 1'b0;
        unique case (state_reg)
            lia_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                ctrl.issue = in_valid;
            end
            lia_pkg::S_EXEC:
            begin
                ctrl.commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* src/lia_pool.sv */
// Pool datapath: free stack memory, free flag memory, stack depth and reset watermark.
// Depends on lia_pkg.
module lia_pool
#(
    parameter int unsigned NUM_IDS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lia_pkg::lia_ctrl_t ctrl,
    input  lia_pkg::lia_in_t   in_data,
    output lia_pkg::lia_out_t  result,
    output logic [$clog2(NUM_IDS+1)-1:0] total
);

    localparam int unsigned ID_W   = $clog2(NUM_IDS);
    localparam int unsigned CNT_W  = $clog2(NUM_IDS + 1);
    localparam int unsigned CMP_W  = (CNT_W > lia_pkg::REQ_ID_W) ? CNT_W : lia_pkg::REQ_ID_W;
    localparam int unsigned SUM_W  = CMP_W + 1;
    localparam int unsigned GNT_XW = (ID_W > lia_pkg::GRANT_W) ? ID_W : lia_pkg::GRANT_W;
    localparam int unsigned CNT_XW = (CNT_W > lia_pkg::COUNT_W) ? CNT_W : lia_pkg::COUNT_W;

    // Memories; stack entries below the watermark have never been written
    logic [ID_W-1:0] stack_mem [NUM_IDS];
    logic            flag_mem  [NUM_IDS];

    logic                         action_reg;
    logic [lia_pkg::REQ_ID_W-1:0] id_reg;
    logic [CNT_W-1:0]             total_reg;
    logic [CNT_W-1:0]             total_next;
    logic [CNT_W-1:0]             low_reg;
    logic [CNT_W-1:0]             low_next;
    logic [ID_W-1:0]              stack_rd_reg;
    logic                         flag_rd_reg;

    logic [CNT_W-1:0]  total_dec;
    logic [ID_W-1:0]   pop_addr;
    logic              fresh_pop;
    logic [ID_W-1:0]   got;
    logic [CMP_W-1:0]  in_id_ext;
    logic [ID_W-1:0]   in_id_idx;
    logic [CMP_W-1:0]  id_ext;
    logic [ID_W-1:0]   id_idx;
    logic              id_in_range;
    logic              id_touched;
    logic              id_free;
    logic              stack_we;
    logic              flag_we;
    logic [ID_W-1:0]   flag_waddr;
    logic              flag_wdata;
    lia_pkg::status_t  status;
    logic [ID_W-1:0]   grant;
    logic [GNT_XW-1:0] grant_ext;
    logic [CNT_XW-1:0] count_ext;

    assign total_dec = total_reg - CNT_W'(1);
    assign pop_addr  = total_dec[ID_W-1:0];
    assign in_id_ext = CMP_W'(in_data.req_id);
    assign in_id_idx = in_id_ext[ID_W-1:0];

    // Latch the request beat
    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            action_reg <= in_data.action;
            id_reg     <= in_data.req_id;
        end
    end

    // Read both memories as the beat is accepted
    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            stack_rd_reg <= stack_mem[pop_addr];
            flag_rd_reg  <= flag_mem[in_id_idx];
        end
    end

    // Write back on commit
    always_ff @(posedge clk)
    begin
        if (ctrl.commit && stack_we)
        begin
            stack_mem[total_reg[ID_W-1:0]] <= id_idx;
        end
        if (ctrl.commit && flag_we)
        begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
    end

    // Stack depth and lowest depth reached since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= CNT_W'(NUM_IDS);
            low_reg   <= CNT_W'(NUM_IDS);
        end
        else if (ctrl.commit)
        begin
            total_reg <= total_next;
            low_reg   <= low_next;
        end
    end

    // Popped entry below the watermark still holds its reset image
    assign fresh_pop = (total_dec < low_reg);
    assign got       = fresh_pop ? (ID_W'(NUM_IDS - 1) - pop_addr) : stack_rd_reg;

    // IDs popped from the reset image have a written flag, the rest are free
    assign id_ext      = CMP_W'(id_reg);
    assign id_idx      = id_ext[ID_W-1:0];
    assign id_in_range = (id_ext < CMP_W'(NUM_IDS));
    assign id_touched  = ((SUM_W'(id_ext) + SUM_W'(low_reg)) < SUM_W'(NUM_IDS));
    assign id_free     = id_touched ? flag_rd_reg : 1'b1;

    // Decide the result and the writeback
    always_comb
    begin
        status     = lia_pkg::ST_OK;
        grant      = '0;
        total_next = total_reg;
        low_next   = low_reg;
        stack_we   = 1'b0;
        flag_we    = 1'b0;
        flag_waddr = id_idx;
        flag_wdata = 1'b1;
        if (action_reg == lia_pkg::ACT_ALLOC)
        begin
            if (total_reg == '0)
            begin
                status = lia_pkg::ST_EMPTY;
            end
            else
            begin
                grant      = got;
                total_next = total_dec;
                if (fresh_pop)
                begin
                    low_next = total_dec;
                end
                flag_we    = 1'b1;
                flag_waddr = got;
                flag_wdata = 1'b0;
            end
        end
        else
        begin
            if (!id_in_range)
            begin
                status = lia_pkg::ST_RANGE;
            end
            else if (id_free || (total_reg == CNT_W'(NUM_IDS)))
            begin
                status = lia_pkg::ST_DUP;
            end
            else
            begin
                stack_we   = 1'b1;
                total_next = total_reg + CNT_W'(1);
                flag_we    = 1'b1;
            end
        end
    end

    // Fit the result to the beat widths
    assign grant_ext = GNT_XW'(grant);
    assign count_ext = CNT_XW'(total_next);

    assign result.status     = status;
    assign result.granted_id = grant_ext[lia_pkg::GRANT_W-1:0];
    assign result.free_count = count_ext[lia_pkg::COUNT_W-1:0];
    assign total             = total_reg;

endmodule

/* src/lifo_id_allocator.sv */
// Top level of the LIFO identifier allocator: sequencer, pool datapath, result register.
// Depends on lia_pkg, lia_ctrl and lia_pool.
//
//  channel | signals                        | beat
//  --------+--------------------------------+-----------------------------------
//  request | in_valid, in_ready, in_data    | action, req_id
//  result  | out_valid, out_ready, out_data | status, granted_id, free_count
//
// For each request the stack and flag memories are read in S_IDLE as the beat is
// accepted, and the entry is written back in S_EXEC as the result is loaded.
// A held result stalls the writeback cycle until the result slot empties.
// Reset needs no clearing pass: a watermark of the lowest stack depth tells which
// entries still hold their reset image, so requests are taken straight out of reset.
module lifo_id_allocator
#(
    parameter int unsigned NUM_IDS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lia_pkg::lia_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lia_pkg::lia_out_t out_data
);

    localparam int unsigned CNT_W = $clog2(NUM_IDS + 1);

    lia_pkg::lia_ctrl_t ctrl;
    lia_pkg::lia_out_t  result;
    lia_pkg::lia_out_t  out_reg;
    logic               out_valid_reg;
    logic               slot_free;
    logic [CNT_W-1:0]   total;

    assign slot_free = !out_valid_reg || out_ready;

    lia_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .slot_free (slot_free),
        .in_ready  (in_ready),
        .ctrl      (ctrl)
    );

    lia_pool #(
        .NUM_IDS (NUM_IDS)
    ) u_pool
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .in_data (in_data),
        .result  (result),
        .total   (total)
    );

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    // Stack depth never exceeds the pool size
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total <= CNT_W'(NUM_IDS))
        else $error("free stack depth above pool size");

    // Pool empty is reported only with an empty stack
    a_empty_real: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit && (result.status == lia_pkg::ST_EMPTY) |-> total == '0)
        else $error("pool empty reported with free IDs left");

    // A successful request moves the stack depth, a rejected one leaves it
    a_ok_moves: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit && (result.status == lia_pkg::ST_OK) |=> total != $past(total))
        else $error("successful request left stack depth unchanged");

    a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit && (result.status != lia_pkg::ST_OK) |=> total == $past(total))
        else $error("rejected request changed stack depth");

    // One request in flight: no new beat right after an accepted one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");
`endif

endmodule
